>>> rtl/core/kwl_pkg.sv
// Keyword lexer package: token record, mode and kind codes, keyword table.
// Character class helpers and the parallel keyword match live here.
// No dependencies.
package kwl_pkg;

  localparam int WordDepth = 10;
  localparam int KwCount   = 33;

  typedef enum logic [9:0] {
    M_IDLE  = 10'b0000000001,
    M_WORD  = 10'b0000000010,
    M_NUM   = 10'b0000000100,
    M_STR   = 10'b0000001000,
    M_CHR   = 10'b0000010000,
    M_GT    = 10'b0000100000,
    M_LT    = 10'b0001000000,
    M_SLASH = 10'b0010000000,
    M_LCOM  = 10'b0100000000,
    M_BCOM  = 10'b1000000000
  } mode_e;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_NUMBER  = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_STRING  = 6'd3;
  localparam logic [5:0] K_CHAR    = 6'd4;
  localparam logic [5:0] K_UNKNOWN = 6'd5;
  localparam logic [5:0] K_NONE    = 6'd0;
  localparam logic [5:0] K_STAR    = 6'd6;
  localparam logic [5:0] K_MOD     = 6'd7;
  localparam logic [5:0] K_TILDE   = 6'd8;
  localparam logic [5:0] K_CARET   = 6'd9;
  localparam logic [5:0] K_BSLASH  = 6'd10;
  localparam logic [5:0] K_ASSIGN  = 6'd11;
  localparam logic [5:0] K_PLUS    = 6'd12;
  localparam logic [5:0] K_MINUS   = 6'd13;
  localparam logic [5:0] K_AMP     = 6'd14;
  localparam logic [5:0] K_PIPE    = 6'd15;
  localparam logic [5:0] K_DOT     = 6'd16;
  localparam logic [5:0] K_GE      = 6'd17;
  localparam logic [5:0] K_SHR     = 6'd18;
  localparam logic [5:0] K_GT      = 6'd19;
  localparam logic [5:0] K_LE      = 6'd20;
  localparam logic [5:0] K_SHL     = 6'd21;
  localparam logic [5:0] K_LT      = 6'd22;
  localparam logic [5:0] K_DIV     = 6'd23;
  localparam logic [5:0] K_KW_BASE = 6'd24;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [23:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  // up to two tokens produced by one byte
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } tok_pair_t;

  // keyword text, right-justified: char i of a length-L word at [(L-1-i)*8 +: 8]
  localparam logic [79:0] KW_TEXT [KwCount] = '{
    80'("while"), 80'("else"), 80'("if"), 80'("break"), 80'("true"),
    80'("false"), 80'("dup"), 80'("2dup"), 80'("swap"), 80'("2swap"),
    80'("roll"), 80'("over"), 80'("2over"), 80'("peek"), 80'("memory"),
    80'("write"), 80'("read"), 80'("store"), 80'("fetch"), 80'("rot"),
    80'("drop"), 80'("2drop"), 80'("end"), 80'("then"), 80'("not"),
    80'("systemcall"), 80'("ascii"), 80'("dump"), 80'("do"), 80'("define"),
    80'("include"), 80'("and"), 80'("or")
  };

  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd5, 4'd4, 4'd2, 4'd5, 4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd5, 4'd4,
    4'd4, 4'd5, 4'd4, 4'd6, 4'd5, 4'd4, 4'd5, 4'd5, 4'd3, 4'd4, 4'd5,
    4'd3, 4'd4, 4'd3, 4'd10, 4'd5, 4'd4, 4'd2, 4'd6, 4'd7, 4'd3, 4'd2
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2a:   k = K_STAR;
      8'h25:   k = K_MOD;
      8'h7e:   k = K_TILDE;
      8'h5e:   k = K_CARET;
      8'h5c:   k = K_BSLASH;
      8'h3d:   k = K_ASSIGN;
      8'h2b:   k = K_PLUS;
      8'h2d:   k = K_MINUS;
      8'h26:   k = K_AMP;
      8'h7c:   k = K_PIPE;
      8'h2e:   k = K_DOT;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // compare the word against every keyword at once
  function automatic logic [5:0] word_kind(logic [7:0] wbuf [WordDepth],
                                           logic [3:0] wlen, logic wlong);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int e = KwCount - 1; e >= 0; e--) begin
      hit = (KW_LEN[e] == wlen);
      for (int i = 0; i < WordDepth; i++) begin
        if (i < int'(KW_LEN[e])) begin
          if (wbuf[i] != KW_TEXT[e][(int'(KW_LEN[e]) - 1 - i) * 8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        k = K_KW_BASE + 6'(e);
      end
    end
    if (wlong) begin
      k = K_IDENT;
    end
    return k;
  endfunction

endpackage

>>> rtl/core/kwl_scan.sv
// Keyword lexer scan stage: scanner state registers and the per-byte step.
// Produces up to two tokens per accepted byte. Uses kwl_pkg.
module kwl_scan #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  output kwl_pkg::tok_pair_t  toks_o
);

  localparam logic [LINE_BITS-1:0]   LineMax = '1;
  localparam logic [OFFSET_BITS-1:0] OffMax  = '1;

  kwl_pkg::mode_e          mode_q, mode_d;
  logic [7:0]              wbuf_q [kwl_pkg::WordDepth];
  logic [7:0]              wbuf_d [kwl_pkg::WordDepth];
  logic [3:0]              wlen_q, wlen_d;
  logic                    wlong_q, wlong_d;
  logic                    star_q, star_d;
  logic [LINE_BITS-1:0]    line_q, line_d;
  logic [OFFSET_BITS-1:0]  off_q, off_d;
  logic [OFFSET_BITS-1:0]  tstart_q, tstart_d;
  logic [15:0]             tlen_q, tlen_d;

  function automatic kwl_pkg::token_t mk(logic [5:0] kind, logic [LINE_BITS-1:0] ln,
                                         logic [OFFSET_BITS-1:0] st, logic [15:0] len);
    logic [31:0] lw;
    logic [31:0] sw;
    kwl_pkg::token_t t;
    lw = 32'(ln);
    sw = 32'(st);
    t.kind  = kind;
    t.line  = lw[15:0];
    t.start = sw[23:0];
    t.len   = len;
    t.last  = 1'b0;
    return t;
  endfunction

  always_comb begin
    kwl_pkg::token_t t [2];
    logic [1:0] n;
    logic       do_begin;
    logic [5:0] k;
    logic [7:0] c;
    c        = byte_i;
    mode_d   = mode_q;
    wbuf_d   = wbuf_q;
    wlen_d   = wlen_q;
    wlong_d  = wlong_q;
    star_d   = star_q;
    line_d   = line_q;
    off_d    = off_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    t[0]     = '0;
    t[1]     = '0;
    n        = 2'd0;
    do_begin = 1'b0;
    k        = kwl_pkg::K_NONE;

    if (c == 8'h00) begin
      k = kwl_pkg::K_NONE;
      case (mode_q)
        kwl_pkg::M_WORD:  k = kwl_pkg::word_kind(wbuf_q, wlen_q, wlong_q);
        kwl_pkg::M_NUM:   k = kwl_pkg::K_NUMBER;
        kwl_pkg::M_STR,
        kwl_pkg::M_CHR:   k = kwl_pkg::K_UNKNOWN;
        kwl_pkg::M_GT:    k = kwl_pkg::K_GT;
        kwl_pkg::M_LT:    k = kwl_pkg::K_LT;
        kwl_pkg::M_SLASH: k = kwl_pkg::K_DIV;
        default:          k = kwl_pkg::K_NONE;
      endcase
      if (k != kwl_pkg::K_NONE) begin
        t[0] = mk(k, line_q, tstart_q, tlen_q);
        n    = 2'd1;
      end
      t[n[0]] = mk(kwl_pkg::K_EOF, line_q, off_q, 16'd0);
      n       = n + 2'd1;
      // end of stream: back to reset state
      mode_d   = kwl_pkg::M_IDLE;
      wlen_d   = 4'd0;
      wlong_d  = 1'b0;
      star_d   = 1'b0;
      line_d   = LINE_BITS'(1);
      off_d    = '0;
      tstart_d = '0;
      tlen_d   = 16'd0;
    end else begin
      case (mode_q)
        kwl_pkg::M_WORD, kwl_pkg::M_NUM: begin
          if (kwl_pkg::is_digit(c) || kwl_pkg::is_alpha(c) ||
              (mode_q == kwl_pkg::M_WORD && c == 8'h5f)) begin
            if (wlen_q < 4'(kwl_pkg::WordDepth)) begin
              wbuf_d[wlen_q] = c;
              wlen_d = wlen_q + 4'd1;
            end else begin
              wlong_d = 1'b1;
            end
            if (tlen_q != 16'hffff) tlen_d = tlen_q + 16'd1;
            if (kwl_pkg::is_alpha(c)) mode_d = kwl_pkg::M_WORD;
          end else begin
            k = (mode_q == kwl_pkg::M_WORD) ? kwl_pkg::word_kind(wbuf_q, wlen_q, wlong_q)
                                             : kwl_pkg::K_NUMBER;
            t[0] = mk(k, line_q, tstart_q, tlen_q);
            n    = 2'd1;
            do_begin = 1'b1;
          end
        end
        kwl_pkg::M_STR, kwl_pkg::M_CHR: begin
          if (tlen_q != 16'hffff) tlen_d = tlen_q + 16'd1;
          if (c == 8'h0a && line_q != LineMax) line_d = line_q + LINE_BITS'(1);
          if (mode_q == kwl_pkg::M_STR && c == 8'h22) begin
            t[0] = mk(kwl_pkg::K_STRING, line_d, tstart_q, tlen_d);
            n    = 2'd1;
            mode_d = kwl_pkg::M_IDLE;
          end else if (mode_q == kwl_pkg::M_CHR && c == 8'h27) begin
            t[0] = mk(kwl_pkg::K_CHAR, line_d, tstart_q, tlen_d);
            n    = 2'd1;
            mode_d = kwl_pkg::M_IDLE;
          end
        end
        kwl_pkg::M_GT, kwl_pkg::M_LT: begin
          if (c == 8'h3d || (mode_q == kwl_pkg::M_GT && c == 8'h3e) ||
              (mode_q == kwl_pkg::M_LT && c == 8'h3c)) begin
            if (tlen_q != 16'hffff) tlen_d = tlen_q + 16'd1;
            if (mode_q == kwl_pkg::M_GT) begin
              k = (c == 8'h3d) ? kwl_pkg::K_GE : kwl_pkg::K_SHR;
            end else begin
              k = (c == 8'h3d) ? kwl_pkg::K_LE : kwl_pkg::K_SHL;
            end
            t[0] = mk(k, line_q, tstart_q, tlen_d);
            n    = 2'd1;
            mode_d = kwl_pkg::M_IDLE;
          end else begin
            k = (mode_q == kwl_pkg::M_GT) ? kwl_pkg::K_GT : kwl_pkg::K_LT;
            t[0] = mk(k, line_q, tstart_q, tlen_q);
            n    = 2'd1;
            do_begin = 1'b1;
          end
        end
        kwl_pkg::M_SLASH: begin
          if (c == 8'h2f) begin
            mode_d = kwl_pkg::M_LCOM;
          end else if (c == 8'h2a) begin
            mode_d = kwl_pkg::M_BCOM;
            star_d = 1'b0;
          end else begin
            t[0] = mk(kwl_pkg::K_DIV, line_q, tstart_q, tlen_q);
            n    = 2'd1;
            do_begin = 1'b1;
          end
        end
        kwl_pkg::M_LCOM: begin
          if (c == 8'h0a) begin
            if (line_q != LineMax) line_d = line_q + LINE_BITS'(1);
            mode_d = kwl_pkg::M_IDLE;
          end
        end
        kwl_pkg::M_BCOM: begin
          if (c == 8'h0a && line_q != LineMax) line_d = line_q + LINE_BITS'(1);
          if (star_q && c == 8'h2f) begin
            mode_d = kwl_pkg::M_IDLE;
            star_d = 1'b0;
          end else begin
            star_d = (c == 8'h2a);
          end
        end
        default: do_begin = 1'b1;
      endcase

      // start a fresh token with this byte
      if (do_begin) begin
        mode_d   = kwl_pkg::M_IDLE;
        tstart_d = off_q;
        tlen_d   = 16'd1;
        wlen_d   = 4'd0;
        wlong_d  = 1'b0;
        k        = kwl_pkg::single_kind(c);
        if (kwl_pkg::is_space(c)) begin
          if (c == 8'h0a && line_q != LineMax) line_d = line_q + LINE_BITS'(1);
        end else if (k != kwl_pkg::K_NONE) begin
          t[n[0]] = mk(k, line_q, off_q, 16'd1);
          n       = n + 2'd1;
        end else if (c == 8'h22) begin
          mode_d = kwl_pkg::M_STR;
        end else if (c == 8'h27) begin
          mode_d = kwl_pkg::M_CHR;
        end else if (c == 8'h3e) begin
          mode_d = kwl_pkg::M_GT;
        end else if (c == 8'h3c) begin
          mode_d = kwl_pkg::M_LT;
        end else if (c == 8'h2f) begin
          mode_d = kwl_pkg::M_SLASH;
        end else if (kwl_pkg::is_digit(c) || kwl_pkg::is_alpha(c) || c == 8'h5f) begin
          wbuf_d[0] = c;
          wlen_d    = 4'd1;
          mode_d    = kwl_pkg::is_digit(c) ? kwl_pkg::M_NUM : kwl_pkg::M_WORD;
        end else begin
          t[n[0]] = mk(kwl_pkg::K_UNKNOWN, line_q, off_q, 16'd1);
          n       = n + 2'd1;
        end
      end

      if (off_q != OffMax) off_d = off_q + OFFSET_BITS'(1);
    end

    if (n == 2'd1) t[0].last = 1'b1;
    if (n == 2'd2) t[1].last = 1'b1;
    toks_o.count = accept_i ? n : 2'd0;
    toks_o.tok0  = t[0];
    toks_o.tok1  = t[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= kwl_pkg::M_IDLE;
      wlen_q   <= 4'd0;
      wlong_q  <= 1'b0;
      star_q   <= 1'b0;
      line_q   <= LINE_BITS'(1);
      off_q    <= '0;
      tstart_q <= '0;
      tlen_q   <= 16'd0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      wlen_q   <= wlen_d;
      wlong_q  <= wlong_d;
      star_q   <= star_d;
      line_q   <= line_d;
      off_q    <= off_d;
      tstart_q <= tstart_d;
      tlen_q   <= tlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      wbuf_q <= wbuf_d;
    end
  end

endmodule

>>> rtl/core/kwl_tok_fifo.sv
// Keyword lexer token queue: four entries, takes up to two tokens a cycle,
// hands out one while not stalled. Uses kwl_pkg.
module kwl_tok_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kwl_pkg::tok_pair_t toks_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               stall_i,
  output kwl_pkg::token_t    tok_o
);

  kwl_pkg::token_t mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = (cnt_q != 3'd0) && !stall_i;
  assign valid_o = (cnt_q != 3'd0);
  assign tok_o   = mem_q[rd_q];
  // need room for two tokens before taking a byte
  assign room_o  = (cnt_q < 3'd3);

  always_comb begin
    wr_d  = wr_q + toks_i.count;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, toks_i.count} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (toks_i.count != 2'd0) mem_q[wr_q] <= toks_i.tok0;
    if (toks_i.count == 2'd2) mem_q[wr_q + 2'd1] <= toks_i.tok1;
  end

endmodule

>>> rtl/core/keyword_lexer.sv
// Keyword lexer top level: scan stage feeding a token queue.
// Depends on kwl_pkg, kwl_scan and kwl_tok_fifo.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+----------------------------------------
//   in      | in_valid_i | in_stall_o  | source_byte_i
//   out     | out_valid_o| out_stall_i | token_kind_o line_number_o
//           |            |             | start_offset_o token_length_o last_of_run_o
//
// One byte per cycle while in_stall_o is low; the scan step is combinational and
// its tokens are registered into the queue with the scan state as the accepting
// cycle ends. A byte that closes a token and opens a one-character token yields
// two words. The input stalls while the four-entry queue lacks room for two words.
// Reset returns to the idle scan state with line 1 and offset 0; so does a zero byte.
module keyword_lexer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  source_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] line_number_o,
  output logic [23:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  kwl_pkg::tok_pair_t toks;
  kwl_pkg::token_t    head;
  logic               room;
  logic               accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  kwl_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (source_byte_i),
    .toks_o  (toks)
  );

  kwl_tok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .toks_i (toks),
    .room_o (room),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .tok_o  (head)
  );

  assign token_kind_o   = head.kind;
  assign line_number_o  = head.line;
  assign start_offset_o = head.start;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule
